FILE: hdl/pearson_correlation_engine_assert.svh
// Assertion macros for the correlation engine checker.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef PEARSON_CORRELATION_ENGINE_ASSERT_SVH
`define PEARSON_CORRELATION_ENGINE_ASSERT_SVH

`define PCE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define PCE_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

FILE: hdl/pce_pkg.sv
// Shared types and constants of the correlation engine.
// No dependencies.
`timescale 1ns / 1ps
package pce_pkg;
  localparam int SampleW  = 16;
  localparam int SumW     = 33;
  localparam int SqSumW   = 48;
  localparam int WordW    = 64;
  localparam int WideW    = 160;
  localparam int CoefW    = 16;
  localparam int QW       = 15;
  localparam int OddSqW   = 30;
  localparam int RhsShift = 30;
  localparam logic [QW-1:0] QOne = 15'd16384;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_FEW  = 2'd1,
    STATUS_FLAT = 2'd2,
    STATUS_OVF  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    OP_NSAA, OP_SA2, OP_NSBB, OP_SB2, OP_NSAB, OP_SASB, OP_PROD, OP_COV2, OP_LHS
  } op_e;

  typedef enum logic [2:0] {
    ST_ACC, ST_CHECK, ST_START, ST_WAIT, ST_SEARCH, ST_EMIT
  } state_e;

  typedef struct packed {
    logic signed [SampleW-1:0] a;
    logic signed [SampleW-1:0] b;
    logic                      last;
  } pair_t;
endpackage

FILE: hdl/pearson_correlation_engine.sv
// Pairs are summed at one per cycle, while no final computation is running, as they leave
// a two-entry input queue. A request with last_pair set starts the final computation on one
// shift-and-add multiplier that handles one multiplier bit per cycle: three products of up
// to 47 multiplier bits, three of up to 32, two of up to 63 and then a bisection of at most
// 15 steps, each a product of up to 30 multiplier bits. A set that is too short or has
// overflowed skips these products, a flat set stops after the fourth product, and meanwhile
// the input queue fills and stops.
// Depends on pce_pkg, pce_front and pce_back.
`timescale 1ns / 1ps
module pearson_correlation_engine import pce_pkg::*; #(
  parameter int MAX_PAIRS   = 65536,
  parameter int SAMPLE_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [SampleW-1:0] sample_a_i,
  input  logic [SampleW-1:0] sample_b_i,
  input  logic               last_pair_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [CoefW-1:0]   coefficient_o,
  output logic [1:0]         status_o
);
  pair_t pair;
  logic  pair_valid, pair_pop;

  pce_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_a_i   (sample_a_i),
    .sample_b_i   (sample_b_i),
    .last_pair_i  (last_pair_i),
    .pair_valid_o (pair_valid),
    .pair_pop_i   (pair_pop),
    .pair_o       (pair)
  );

  pce_back #(.MAX_PAIRS(MAX_PAIRS)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pair_valid_i  (pair_valid),
    .pair_pop_o    (pair_pop),
    .pair_i        (pair),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .coefficient_o (coefficient_o),
    .status_o      (status_o)
  );
endmodule

FILE: hdl/pce_front.sv
// Input side: takes pairs, sign-extends them and holds them in a two-entry queue.
// Depends on pce_pkg.
`timescale 1ns / 1ps
module pce_front import pce_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [SampleW-1:0] sample_a_i,
  input  logic [SampleW-1:0] sample_b_i,
  input  logic               last_pair_i,
  output logic               pair_valid_o,
  input  logic               pair_pop_i,
  output pair_t              pair_o
);
  localparam int Shift = SampleW - SAMPLE_BITS;

  pair_t       mem_q [2];
  logic        wr_q, wr_d, rd_q, rd_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        push, pop;
  pair_t       item;
  logic signed [SampleW-1:0] a_sh, b_sh;

  assign a_sh = $signed(sample_a_i << Shift);
  assign b_sh = $signed(sample_b_i << Shift);

  always_comb begin
    item.a    = a_sh >>> Shift;
    item.b    = b_sh >>> Shift;
    item.last = last_pair_i;
  end

  assign in_ready_o   = (cnt_q != 2'd2);
  assign pair_valid_o = (cnt_q != 2'd0);
  assign pair_o       = mem_q[rd_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = pair_pop_i && pair_valid_o;

  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= item;
    end
  end
endmodule

FILE: hdl/pce_serial_mul.sv
// Shift-and-add multiplier, one multiplier bit per cycle, product truncated to the wide word.
// Depends on pce_pkg.
`timescale 1ns / 1ps
module pce_serial_mul import pce_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WideW-1:0] x_i,
  input  logic [WordW-1:0] y_i,
  output logic             done_o,
  output logic [WideW-1:0] product_o
);
  logic             busy_q, busy_d;
  logic [WideW-1:0] x_q, x_d, acc_q, acc_d;
  logic [WordW-1:0] y_q, y_d;

  assign done_o    = busy_q && (y_q == '0);
  assign product_o = acc_q;

  always_comb begin
    busy_d = busy_q;
    x_d    = x_q;
    y_d    = y_q;
    acc_d  = acc_q;
    if (start_i) begin
      busy_d = 1'b1;
      x_d    = x_i;
      y_d    = y_i;
      acc_d  = '0;
    end else if (busy_q) begin
      if (y_q == '0) begin
        busy_d = 1'b0;
      end else begin
        acc_d = y_q[0] ? acc_q + x_q : acc_q;
        x_d   = x_q << 1;
        y_d   = y_q >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    acc_q <= acc_d;
  end
endmodule

FILE: hdl/pce_back.sv
// Back end: running sums, the final sequencer and the result register.
// Depends on pce_pkg and pce_serial_mul.
`timescale 1ns / 1ps
module pce_back import pce_pkg::*; #(
  parameter int MAX_PAIRS = 65536
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               pair_valid_i,
  output logic               pair_pop_o,
  input  pair_t              pair_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [CoefW-1:0]   coefficient_o,
  output logic [1:0]         status_o
);
  localparam int CountW = $clog2(MAX_PAIRS + 2);
  localparam logic [CountW-1:0] CountMax = CountW'(MAX_PAIRS);

  state_e state_q, state_d;
  op_e    op_q, op_d;
  logic signed [SumW-1:0]   sum_a_q, sum_a_d, sum_b_q, sum_b_d;
  logic [SqSumW-1:0]        sum_aa_q, sum_aa_d, sum_bb_q, sum_bb_d;
  logic signed [SqSumW-1:0] sum_ab_q, sum_ab_d;
  logic [CountW-1:0]        count_q, count_d;
  logic [WordW-1:0]         t0_q, t0_d;
  logic signed [WordW-1:0]  var_a_q, var_a_d, var_b_q, var_b_d, cov_q, cov_d;
  logic [WideW-1:0]         pvar_q, pvar_d, rhs_q, rhs_d;
  logic [QW-1:0]            lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [OddSqW-1:0]        sq_q, sq_d;
  logic [CoefW-1:0]         res_coef_q, res_coef_d, out_coef_q, out_coef_d;
  status_e                  res_status_q, res_status_d, out_status_q, out_status_d;
  logic                     out_valid_q, out_valid_d;

  logic             mul_start, mul_done;
  logic [WideW-1:0] mul_x, mul_prod;
  logic [WordW-1:0] mul_y, p64;
  logic [SumW-1:0]  mag_a, mag_b;
  logic [SqSumW-1:0] mag_ab;
  logic [WordW-1:0] cov_mag;
  logic signed [WordW-1:0] term0, term1;
  logic signed [2*SampleW-1:0] prod_aa, prod_bb, prod_ab;
  logic [QW:0]      mid_sum;
  logic [QW-1:0]    odd;

  assign mag_a   = sum_a_q[SumW-1] ? SumW'(-sum_a_q) : SumW'(sum_a_q);
  assign mag_b   = sum_b_q[SumW-1] ? SumW'(-sum_b_q) : SumW'(sum_b_q);
  assign mag_ab  = sum_ab_q[SqSumW-1] ? SqSumW'(-sum_ab_q) : SqSumW'(sum_ab_q);
  assign cov_mag = cov_q[WordW-1] ? WordW'(-cov_q) : WordW'(cov_q);
  assign p64     = mul_prod[WordW-1:0];
  assign prod_aa = pair_i.a * pair_i.a;
  assign prod_bb = pair_i.b * pair_i.b;
  assign prod_ab = pair_i.a * pair_i.b;
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q} + (QW+1)'(1);
  assign mid_d   = mid_sum[QW:1];
  assign odd     = QW'({mid_d, 1'b0} - (QW+1)'(1));

  always_comb begin
    mul_x = '0;
    mul_y = '0;
    unique case (op_q)
      OP_NSAA: begin mul_x = WideW'(count_q); mul_y = WordW'(sum_aa_q); end
      OP_SA2:  begin mul_x = WideW'(mag_a);   mul_y = WordW'(mag_a);    end
      OP_NSBB: begin mul_x = WideW'(count_q); mul_y = WordW'(sum_bb_q); end
      OP_SB2:  begin mul_x = WideW'(mag_b);   mul_y = WordW'(mag_b);    end
      OP_NSAB: begin mul_x = WideW'(count_q); mul_y = WordW'(mag_ab);   end
      OP_SASB: begin mul_x = WideW'(mag_a);   mul_y = WordW'(mag_b);    end
      OP_PROD: begin
        mul_x = WideW'($unsigned(var_a_q));
        mul_y = $unsigned(var_b_q);
      end
      OP_COV2: begin mul_x = WideW'(cov_mag); mul_y = cov_mag;          end
      OP_LHS:  begin mul_x = pvar_q;          mul_y = WordW'(sq_q);     end
      default: begin mul_x = '0;              mul_y = '0;               end
    endcase
  end

  assign mul_start = (state_q == ST_START);

  pce_serial_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .x_i       (mul_x),
    .y_i       (mul_y),
    .done_o    (mul_done),
    .product_o (mul_prod)
  );

  assign term0 = sum_ab_q[SqSumW-1] ? -$signed(t0_q) : $signed(t0_q);
  assign term1 = (sum_a_q[SumW-1] ^ sum_b_q[SumW-1]) ? -$signed(p64) : $signed(p64);

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    sum_a_d      = sum_a_q;
    sum_b_d      = sum_b_q;
    sum_aa_d     = sum_aa_q;
    sum_bb_d     = sum_bb_q;
    sum_ab_d     = sum_ab_q;
    count_d      = count_q;
    t0_d         = t0_q;
    var_a_d      = var_a_q;
    var_b_d      = var_b_q;
    cov_d        = cov_q;
    pvar_d       = pvar_q;
    rhs_d        = rhs_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    sq_d         = sq_q;
    res_coef_d   = res_coef_q;
    res_status_d = res_status_q;
    out_coef_d   = out_coef_q;
    out_status_d = out_status_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    pair_pop_o   = 1'b0;
    unique case (state_q)
      ST_ACC: begin
        pair_pop_o = pair_valid_i;
        if (pair_valid_i) begin
          if (count_q < CountMax) begin
            sum_a_d  = sum_a_q + SumW'(pair_i.a);
            sum_b_d  = sum_b_q + SumW'(pair_i.b);
            sum_aa_d = sum_aa_q + SqSumW'($unsigned(prod_aa));
            sum_bb_d = sum_bb_q + SqSumW'($unsigned(prod_bb));
            sum_ab_d = sum_ab_q + SqSumW'(prod_ab);
            count_d  = count_q + CountW'(1);
          end else begin
            count_d = CountMax + CountW'(1);
          end
          if (pair_i.last) begin
            state_d = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        res_coef_d = '0;
        priority if (count_q > CountMax) begin
          res_status_d = STATUS_OVF;
          state_d      = ST_EMIT;
        end else if (count_q < CountW'(2)) begin
          res_status_d = STATUS_FEW;
          state_d      = ST_EMIT;
        end else begin
          res_status_d = STATUS_OK;
          op_d         = OP_NSAA;
          state_d      = ST_START;
        end
      end
      ST_START: begin
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (mul_done) begin
          state_d = ST_START;
          unique case (op_q)
            OP_NSAA: begin t0_d = p64; op_d = OP_SA2; end
            OP_SA2:  begin var_a_d = $signed(t0_q - p64); op_d = OP_NSBB; end
            OP_NSBB: begin t0_d = p64; op_d = OP_SB2; end
            OP_SB2: begin
              var_b_d = $signed(t0_q - p64);
              if (var_a_q[WordW-1] || var_a_q == '0 || var_b_d[WordW-1] || var_b_d == '0)
              begin
                res_status_d = STATUS_FLAT;
                state_d      = ST_EMIT;
              end else begin
                op_d = OP_NSAB;
              end
            end
            OP_NSAB: begin t0_d = p64; op_d = OP_SASB; end
            OP_SASB: begin cov_d = term0 - term1; op_d = OP_PROD; end
            OP_PROD: begin pvar_d = mul_prod; op_d = OP_COV2; end
            OP_COV2: begin
              rhs_d   = mul_prod << RhsShift;
              lo_d    = '0;
              hi_d    = QOne;
              state_d = ST_SEARCH;
            end
            OP_LHS: begin
              if (mul_prod <= rhs_q) begin
                lo_d = mid_q;
              end else begin
                hi_d = mid_q - QW'(1);
              end
              state_d = ST_SEARCH;
            end
            default: state_d = ST_EMIT;
          endcase
        end
      end
      ST_SEARCH: begin
        if (lo_q < hi_q) begin
          sq_d    = OddSqW'(odd * odd);
          op_d    = OP_LHS;
          state_d = ST_START;
        end else begin
          res_coef_d = cov_q[WordW-1] ? CoefW'(-{1'b0, lo_q}) : CoefW'({1'b0, lo_q});
          state_d    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_coef_d   = res_coef_q;
          out_status_d = res_status_q;
          sum_a_d      = '0;
          sum_b_d      = '0;
          sum_aa_d     = '0;
          sum_bb_d     = '0;
          sum_ab_d     = '0;
          count_d      = '0;
          state_d      = ST_ACC;
        end
      end
      default: state_d = ST_ACC;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACC;
      op_q        <= OP_NSAA;
      sum_a_q     <= '0;
      sum_b_q     <= '0;
      sum_aa_q    <= '0;
      sum_bb_q    <= '0;
      sum_ab_q    <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      sum_a_q     <= sum_a_d;
      sum_b_q     <= sum_b_d;
      sum_aa_q    <= sum_aa_d;
      sum_bb_q    <= sum_bb_d;
      sum_ab_q    <= sum_ab_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t0_q         <= t0_d;
    var_a_q      <= var_a_d;
    var_b_q      <= var_b_d;
    cov_q        <= cov_d;
    pvar_q       <= pvar_d;
    rhs_q        <= rhs_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    mid_q        <= (state_q == ST_SEARCH) ? mid_d : mid_q;
    sq_q         <= sq_d;
    res_coef_q   <= res_coef_d;
    res_status_q <= res_status_d;
    out_coef_q   <= out_coef_d;
    out_status_q <= out_status_d;
  end

  assign out_valid_o   = out_valid_q;
  assign coefficient_o = out_coef_q;
  assign status_o      = out_status_q;
endmodule

FILE: hdl/pce_checker.sv
// Port-level checks on the correlation engine results, bound to the top level.
// Depends on pce_pkg and pearson_correlation_engine_assert.svh.
`timescale 1ns / 1ps
`include "pearson_correlation_engine_assert.svh"
module pce_checker import pce_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic [SampleW-1:0] sample_a_i,
  input logic [SampleW-1:0] sample_b_i,
  input logic               last_pair_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [CoefW-1:0]   coefficient_o,
  input logic [1:0]         status_o
);
  `PCE_ASSERT(a_fail_zero, !out_valid_o || status_o == STATUS_OK || coefficient_o == '0, "nonzero coefficient with error status")
  `PCE_ASSERT(a_range, !out_valid_o || ($signed(coefficient_o) <= 16384 && $signed(coefficient_o) >= -16384), "coefficient out of range")
  `PCE_ASSERT_NEXT(a_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(coefficient_o) && $stable(status_o), "result dropped or changed while stalled")
  `PCE_ASSERT_NEXT(a_in_hold, in_valid_i && !in_ready_o, in_valid_i && $stable(sample_a_i) && $stable(sample_b_i) && $stable(last_pair_i), "request dropped or changed while stalled")
endmodule

bind pearson_correlation_engine pce_checker u_pce_checker (.*);
